// ----- hdl/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants for the sensor frame builder
// Request layout, frame constants and the CRC-8 (reflected 0x8C) byte update.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int MAX_RECORDS  = 3;
    localparam int RECORD_SLOTS = 3;
    localparam int COUNT_LIMIT  = (MAX_RECORDS < RECORD_SLOTS) ? MAX_RECORDS : RECORD_SLOTS;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] MSG_TYPE_SENSOR = 8'h01;
    localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;
    localparam logic [7:0] CRC_INIT        = 8'h00;
    localparam logic [7:0] NODE_ID_RESET   = 8'h01;

    typedef logic [RECORD_SLOTS-1:0][7:0]  type_slots_t;
    typedef logic [RECORD_SLOTS-1:0][15:0] value_slots_t;

    // one frame request as it travels from front to back
    typedef struct packed {
        logic [7:0]   node_id;
        logic [1:0]   count;
        type_slots_t  types;
        value_slots_t values;
    } req_t;

    // CRC-8/MAXIM update, LSB first
    function automatic logic [7:0] crc_update(input logic [7:0] crc_in,
                                              input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++) begin
            if ((crc[0] ^ data[0]) == 1'b1) begin
                crc = (crc >> 1) ^ CRC_POLY_REFL;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- hdl/sensor_frame_builder_crc8.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc8: sensor frame serialiser with CRC-8/MAXIM trailer
// Turns one request of up to three records into a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Each accepted request produces the frame node id, 0x01, record count, then per
// record its type, value high byte and value low byte, then a CRC-8/MAXIM byte
// (reflected poly 0x8C, init 0x00) over all earlier bytes; only the CRC byte has
// m_final_byte set. A count of zero produces no output; a count above MAX_RECORDS
// is clamped and the clamped value is sent. The output runs at one byte per cycle
// while m_ready is high, and a request with n records makes a frame of 3*n + 4
// bytes (7 to 13), set by the serialiser's byte sequencer; the intake stage and a
// two-entry request queue let new requests be taken while a frame is still being
// sent. cfg_data sets the node id (reset 0x01); it is always ready and should only
// be written while the block is idle.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc8 (
    input  logic               aclk,
    input  logic               aresetn,

    // configuration: node identifier
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,

    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_record_count,
    input  logic [7:0]         s_sensor_type_0,
    input  logic signed [15:0] s_sensor_value_0,
    input  logic [7:0]         s_sensor_type_1,
    input  logic signed [15:0] s_sensor_value_1,
    input  logic [7:0]         s_sensor_type_2,
    input  logic signed [15:0] s_sensor_value_2,

    // frame byte channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_frame_byte,
    output logic               m_final_byte
);

    logic [7:0]    node_id_reg;
    logic [7:0]    node_id_next;
    sfb_pkg::req_t in_req;

    logic          f2q_valid;
    logic          f2q_ready;
    sfb_pkg::req_t f2q_req;
    logic          q2b_valid;
    logic          q2b_ready;
    sfb_pkg::req_t q2b_req;

    // config register: always accepts
    assign cfg_ready    = 1'b1;
    assign node_id_next = (cfg_valid && cfg_ready) ? cfg_data : node_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= sfb_pkg::NODE_ID_RESET;
        end else begin
            node_id_reg <= node_id_next;
        end
    end

    // pack the request; node id is captured with it
    always_comb begin
        in_req.node_id   = node_id_reg;
        in_req.count     = s_record_count;
        in_req.types[0]  = s_sensor_type_0;
        in_req.types[1]  = s_sensor_type_1;
        in_req.types[2]  = s_sensor_type_2;
        in_req.values[0] = $unsigned(s_sensor_value_0);
        in_req.values[1] = $unsigned(s_sensor_value_1);
        in_req.values[2] = $unsigned(s_sensor_value_2);
    end

    sfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (in_req),
        .out_valid (f2q_valid),
        .out_ready (f2q_ready),
        .out_req   (f2q_req)
    );

    sfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f2q_valid),
        .push_ready (f2q_ready),
        .push_req   (f2q_req),
        .pop_valid  (q2b_valid),
        .pop_ready  (q2b_ready),
        .pop_req    (q2b_req)
    );

    sfb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (q2b_valid),
        .req_ready    (q2b_ready),
        .req_in       (q2b_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_final_byte (m_final_byte)
    );

endmodule

// ----- hdl/sfb_front.sv -----
// ----------------------------------------------------------------------------
// sfb_front: request intake
// Registers each request, clamps the record count and drops empty requests.
// ----------------------------------------------------------------------------
module sfb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sfb_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output sfb_pkg::req_t out_req
);

    logic          valid_reg;
    logic          valid_next;
    sfb_pkg::req_t req_reg;
    sfb_pkg::req_t req_next;
    logic [1:0]    count_clamped;
    logic          accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_req   = req_reg;

    always_comb begin
        if (in_req.count > 2'(sfb_pkg::COUNT_LIMIT)) begin
            count_clamped = 2'(sfb_pkg::COUNT_LIMIT);
        end else begin
            count_clamped = in_req.count;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            // empty request: nothing to send
            valid_next     = (count_clamped != 2'd0);
            req_next       = in_req;
            req_next.count = count_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    a_front_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (req_reg.count != 2'd0 &&
                       req_reg.count <= 2'(sfb_pkg::COUNT_LIMIT)))
        else $error("front holds an empty or unclamped request");

endmodule

// ----- hdl/sfb_queue.sv -----
// ----------------------------------------------------------------------------
// sfb_queue: request queue
// Small FIFO of clamped requests between intake and serialiser.
// ----------------------------------------------------------------------------
module sfb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  sfb_pkg::req_t push_req,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sfb_pkg::req_t pop_req
);

    localparam int PTR_W = (sfb_pkg::QUEUE_DEPTH > 1) ? $clog2(sfb_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sfb_pkg::QUEUE_DEPTH + 1);

    sfb_pkg::req_t            entry_reg [sfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     push;
    logic                     pop;

    assign push_ready = (fill_reg != CNT_W'(sfb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_req    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sfb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sfb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    a_queue_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(sfb_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_queue_ptrs_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");

endmodule

// ----- hdl/sfb_back.sv -----
// ----------------------------------------------------------------------------
// sfb_back: frame serialiser
// Walks one request byte by byte, folds each byte into the CRC, appends it.
// ----------------------------------------------------------------------------
module sfb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  sfb_pkg::req_t req_in,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_byte,
    output logic          m_final_byte
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_NODE     = 3'd1;
    localparam logic [2:0] ST_MSG      = 3'd2;
    localparam logic [2:0] ST_COUNT    = 3'd3;
    localparam logic [2:0] ST_REC_TYPE = 3'd4;
    localparam logic [2:0] ST_REC_HI   = 3'd5;
    localparam logic [2:0] ST_REC_LO   = 3'd6;
    localparam logic [2:0] ST_CRC      = 3'd7;

    localparam int REC_W = (sfb_pkg::RECORD_SLOTS > 1) ? $clog2(sfb_pkg::RECORD_SLOTS) : 1;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [REC_W-1:0] rec_reg;
    logic [REC_W-1:0] rec_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    sfb_pkg::req_t    req_reg;
    sfb_pkg::req_t    req_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [7:0]       m_frame_byte_reg;
    logic [7:0]       m_frame_byte_next;
    logic             m_final_byte_reg;
    logic             m_final_byte_next;

    logic             out_free;
    logic             step;
    logic             last_rec;
    logic [7:0]       cur_byte;
    logic [15:0]      cur_value;

    assign out_free  = !m_valid_reg || m_ready;
    assign step      = (state_reg != ST_IDLE) && out_free;
    assign req_ready = (state_reg == ST_IDLE) || (step && state_reg == ST_CRC);
    assign cur_value = req_reg.values[rec_reg];
    assign last_rec  = (2'(rec_reg) == req_reg.count - 2'd1);

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_final_byte = m_final_byte_reg;

    always_comb begin
        unique case (state_reg)
            ST_NODE:     cur_byte = req_reg.node_id;
            ST_MSG:      cur_byte = sfb_pkg::MSG_TYPE_SENSOR;
            ST_COUNT:    cur_byte = {6'd0, req_reg.count};
            ST_REC_TYPE: cur_byte = req_reg.types[rec_reg];
            ST_REC_HI:   cur_byte = cur_value[15:8];
            ST_REC_LO:   cur_byte = cur_value[7:0];
            ST_CRC:      cur_byte = crc_reg;
            default:     cur_byte = 8'd0;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        rec_next          = rec_reg;
        crc_next          = crc_reg;
        req_next          = req_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_frame_byte_next = m_frame_byte_reg;
        m_final_byte_next = m_final_byte_reg;

        if (step) begin
            m_valid_next      = 1'b1;
            m_frame_byte_next = cur_byte;
            m_final_byte_next = (state_reg == ST_CRC);
            crc_next          = sfb_pkg::crc_update(crc_reg, cur_byte);
            unique case (state_reg)
                ST_NODE:     state_next = ST_MSG;
                ST_MSG:      state_next = ST_COUNT;
                ST_COUNT:    state_next = ST_REC_TYPE;
                ST_REC_TYPE: state_next = ST_REC_HI;
                ST_REC_HI:   state_next = ST_REC_LO;
                ST_REC_LO: begin
                    if (last_rec) begin
                        state_next = ST_CRC;
                    end else begin
                        state_next = ST_REC_TYPE;
                        rec_next   = rec_reg + 1'b1;
                    end
                end
                ST_CRC:      state_next = ST_IDLE;
                default:     state_next = ST_IDLE;
            endcase
        end

        // next frame starts straight after the CRC byte
        if (req_valid && req_ready) begin
            state_next = ST_NODE;
            rec_next   = '0;
            crc_next   = sfb_pkg::CRC_INIT;
            req_next   = req_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg          <= rec_next;
        crc_reg          <= crc_next;
        req_reg          <= req_next;
        m_frame_byte_reg <= m_frame_byte_next;
        m_final_byte_reg <= m_final_byte_next;
    end

    a_back_rec_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REC_TYPE || state_reg == ST_REC_HI || state_reg == ST_REC_LO)
        |-> (2'(rec_reg) < req_reg.count))
        else $error("record index past clamped count");

    a_back_crc_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC && out_free) |=> (m_valid_reg && m_final_byte_reg))
        else $error("CRC byte not flagged final");

    a_back_header_not_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NODE && out_free) |=> (m_valid_reg && !m_final_byte_reg))
        else $error("header byte flagged final");

endmodule

// ----- dv/sensor_frame_builder_crc8_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc8_test: self-checking bench for the frame builder
// Requests go in from a queue through a clocked driver. Each accepted request
// is turned into its expected frame bytes, CRC-8/MAXIM trailer included. A
// clocked monitor checks every output item against the oldest expected byte.
// Three idling phases are run, and the node id is rewritten between phases.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc8_test;

    localparam int DRAIN_CYCLES = 64;        // intake + 2-deep queue + 13-byte frame, padded
    localparam int TIMEOUT_NS   = 2_000_000; // far above the slowest run

    // one frame request as the driver presents it
    typedef struct packed {
        logic [1:0]                             count;
        logic [sfb_pkg::RECORD_SLOTS-1:0][7:0]  kinds;
        logic [sfb_pkg::RECORD_SLOTS-1:0][15:0] readings;
    } frame_req_t;

    // one expected output item
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       final_byte;
    } frame_item_t;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_valid        = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data         = 8'h00;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [1:0]         s_record_count   = '0;
    logic [7:0]         s_sensor_type_0  = '0;
    logic signed [15:0] s_sensor_value_0 = '0;
    logic [7:0]         s_sensor_type_1  = '0;
    logic signed [15:0] s_sensor_value_1 = '0;
    logic [7:0]         s_sensor_type_2  = '0;
    logic signed [15:0] s_sensor_value_2 = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [7:0]         m_frame_byte;
    logic               m_final_byte;

    frame_req_t  pending_reqs[$];     // filled by the stimulus, drained by the driver
    frame_item_t frame_bytes_due[$];  // expected bytes, oldest first
    int          reqs_outstanding = 0;   // queued but not yet accepted
    int          send_idle_pct    = 0;
    int          recv_idle_pct    = 0;
    int          fail_count       = 0;
    logic [7:0]  node_id_shadow   = sfb_pkg::NODE_ID_RESET;

    sensor_frame_builder_crc8 u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_record_count   (s_record_count),
        .s_sensor_type_0  (s_sensor_type_0),
        .s_sensor_value_0 (s_sensor_value_0),
        .s_sensor_type_1  (s_sensor_type_1),
        .s_sensor_value_1 (s_sensor_value_1),
        .s_sensor_type_2  (s_sensor_type_2),
        .s_sensor_value_2 (s_sensor_value_2),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_final_byte     (m_final_byte)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------------

    // CRC-8/MAXIM, reflected: fold the byte in first, then shift out eight bits
    function automatic logic [7:0] maxim_crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = r[0] ? ((r >> 1) ^ sfb_pkg::CRC_POLY_REFL) : (r >> 1);
        return r;
    endfunction

    // queue one non-final frame byte and fold it into the running CRC
    function automatic void push_frame_byte(input logic [7:0] b, inout logic [7:0] crc);
        frame_bytes_due.push_back('{frame_byte: b, final_byte: 1'b0});
        crc = maxim_crc_step(crc, b);
    endfunction

    // expected frame for one accepted request: header, records, CRC trailer
    function automatic void predict_frame(input frame_req_t rq);
        logic [7:0] crc;
        int         n;
        n   = (int'(rq.count) > sfb_pkg::COUNT_LIMIT) ? sfb_pkg::COUNT_LIMIT
                                                      : int'(rq.count);
        crc = sfb_pkg::CRC_INIT;
        if (n == 0) return;   // zero count: nothing goes out
        push_frame_byte(node_id_shadow, crc);
        push_frame_byte(sfb_pkg::MSG_TYPE_SENSOR, crc);
        push_frame_byte(8'(n), crc);
        // records past the clamped count never reach the wire
        for (int k = 0; k < n; k++) begin
            push_frame_byte(rq.kinds[k], crc);
            push_frame_byte(rq.readings[k][15:8], crc);
            push_frame_byte(rq.readings[k][7:0], crc);
        end
        frame_bytes_due.push_back('{frame_byte: crc, final_byte: 1'b1});
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: takes the next item when the slot frees, idles at random
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : req_driver
        frame_req_t rq;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame('{count: s_record_count,
                                kinds: {s_sensor_type_2, s_sensor_type_1, s_sensor_type_0},
                                readings: {s_sensor_value_2, s_sensor_value_1,
                                           s_sensor_value_0}});
                reqs_outstanding--;
            end
            // the held item stays put until it has been taken
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = pending_reqs.pop_front();
                    s_record_count   <= rq.count;
                    s_sensor_type_0  <= rq.kinds[0];
                    s_sensor_value_0 <= rq.readings[0];
                    s_sensor_type_1  <= rq.kinds[1];
                    s_sensor_value_1 <= rq.readings[1];
                    s_sensor_type_2  <= rq.kinds[2];
                    s_sensor_value_2 <= rq.readings[2];
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Frame monitor: each taken byte against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : frame_monitor
        frame_item_t due;
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected frame item: frame_byte %02h final_byte %0b",
                       m_frame_byte, m_final_byte);
                fail_count++;
            end else begin
                due = frame_bytes_due.pop_front();
                if (m_frame_byte !== due.frame_byte) begin
                    $error("frame_byte: expected %02h, got %02h",
                           due.frame_byte, m_frame_byte);
                    fail_count++;
                end
                if (m_final_byte !== due.final_byte) begin
                    $error("final_byte: expected %0b, got %0b",
                           due.final_byte, m_final_byte);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] cnt,
                             input logic [7:0] t0, input logic [15:0] v0,
                             input logic [7:0] t1, input logic [15:0] v1,
                             input logic [7:0] t2, input logic [15:0] v2);
        pending_reqs.push_back('{count: cnt, kinds: {t2, t1, t0}, readings: {v2, v1, v0}});
        reqs_outstanding++;
    endtask

    // mostly real frames, the odd empty request
    task automatic queue_random_reqs(input int n);
        logic [1:0] cnt;
        for (int i = 0; i < n; i++) begin
            cnt = ($urandom_range(15) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
            queue_req(cnt, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom), 16'($urandom));
        end
    endtask

    // all taken, all bytes seen, then room for trailing empty requests to clear
    task automatic wait_until_idle();
        while (reqs_outstanding != 0) @(posedge aclk);
        while (frame_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_id(input logic [7:0] id);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        node_id_shadow = id;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender idles a little, receiver a lot; node id at reset, then 0xFF
        send_idle_pct = 15;
        recv_idle_pct = 74;
        queue_req(2'd0, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF); // empty request
        queue_req(2'd1, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
        queue_req(2'd1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF); // unused slots set
        queue_req(2'd2, 8'h5A, 16'h8000, 8'hA5, 16'h7FFF, 8'hFF, 16'hFFFF);
        queue_req(2'd3, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF); // full count
        queue_req(2'd3, 8'h00, 16'h8000, 8'h7F, 16'h7FFF, 8'h80, 16'h0001);
        queue_req(2'd3, 8'h01, 16'h0100, 8'h02, 16'hFF00, 8'h03, 16'h00FF);
        queue_req(2'd0, 8'h12, 16'h3456, 8'h78, 16'h9ABC, 8'hDE, 16'hF012);
        queue_req(2'd0, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
        queue_req(2'd2, 8'h00, 16'h0000, 8'hFF, 16'hFFFF, 8'h00, 16'h0000);
        queue_req(2'd1, 8'h80, 16'h8000, 8'h00, 16'h0000, 8'h00, 16'h0000);
        queue_req(2'd1, 8'h7F, 16'h7FFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_req(2'd3, 8'hAA, 16'h5555, 8'h55, 16'hAAAA, 8'hC3, 16'h3CC3);
        wait_until_idle();

        write_node_id(8'hFF);
        queue_random_reqs(70);
        wait_until_idle();

        // phase 2: roles swapped
        write_node_id(8'h00);
        send_idle_pct = 74;
        recv_idle_pct = 15;
        queue_random_reqs(90);
        wait_until_idle();

        // phase 3: full rate both sides
        write_node_id(8'($urandom_range(254, 2)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_reqs(90);
        wait_until_idle();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
